// ===== hw/rtl/mcs_pkg.sv =====
// ----------------------------------------------------------------------------
// mcs_pkg
// Types and constants of the Markov chain sampler.
// ----------------------------------------------------------------------------
package mcs_pkg;

    localparam int STATE_COUNT        = 4;
    localparam int PROB_FRACTION_BITS = 16;
    localparam int IDX_W   = 2;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = STATE_COUNT * STATE_COUNT;
    localparam int PROB_W  = PROB_FRACTION_BITS + 1;
    localparam int SUM_W   = PROB_W + 3;
    localparam int NUM_W   = PROB_W + PROB_FRACTION_BITS;
    localparam int QUO_W   = NUM_W;
    localparam int CNT_W   = 10;
    localparam logic [PROB_W-1:0] UNIFORM_PROB = PROB_W'((1 << PROB_FRACTION_BITS) / STATE_COUNT);
    localparam logic [PROB_W-1:0] PROB_MAX     = {PROB_W{1'b1}};
    localparam logic [IDX_W-1:0]  LAST_STATE   = IDX_W'(STATE_COUNT - 1);

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_STEADY = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       row_index;
        logic [1:0]       column_index;
        logic [15:0]      weight_value;
        logic             load_end;
        logic [1:0]       current_state;
        logic [15:0]      random_value;
        logic [CNT_W-1:0] iteration_count;
    } in_item_t;

    typedef struct packed {
        logic              result_kind;
        logic [1:0]        next_state;
        logic [1:0]        entry_index;
        logic [PROB_W-1:0] probability;
        logic              last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SAMP,
        ST_NSUM,
        ST_NDIV,
        ST_NWR,
        ST_PINIT,
        ST_PMUL,
        ST_PCOPY,
        ST_EMIT
    } fsm_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [SUM_W-1:0]  den;
    } div_req_t;

endpackage

// ===== hw/rtl/mcs_ram.sv =====
// ----------------------------------------------------------------------------
// mcs_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mcs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/mcs_div.sv =====
// ----------------------------------------------------------------------------
// mcs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcs_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mcs_pkg::div_req_t        req,
    output logic                     done,
    output logic [mcs_pkg::QUO_W-1:0] quo
);
    localparam int NW = mcs_pkg::NUM_W;
    localparam int DW = mcs_pkg::SUM_W;

    logic [NW-1:0]          q_reg, q_next;
    logic [DW:0]            r_reg, r_next;
    logic [DW-1:0]          d_reg, d_next;
    logic [$clog2(NW+1)-1:0] n_reg, n_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DW:0]            sh;

    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg; n_next = n_reg;
        busy_next = busy_reg; done_next = 1'b0;
        sh = '0;
        if (req.start) begin
            q_next = req.num; r_next = '0; d_next = req.den;
            n_next = ($clog2(NW+1))'(NW); busy_next = 1'b1;
        end else if (busy_reg) begin
            sh = {r_reg[DW-1:0], q_reg[NW-1]};
            if (sh >= {1'b0, d_reg}) begin
                r_next = sh - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = sh;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == 1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next; n_reg <= n_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

// ===== hw/rtl/markov_chain_sampler.sv =====
// ----------------------------------------------------------------------------
// markov_chain_sampler
// Transition table in a synchronous RAM; sampling, row normalisation and
// power iteration by a sequencer with one multiplier and a serial divider.
// ----------------------------------------------------------------------------
//  channel | direction | content
//  s_      | in        | in_item_t: load, sample or steady-state request
//  m_      | out       | out_item_t: sampled state or distribution entry
//
//  A load writes one table entry; a sample adds up its row's weights from column 0 until
//  the random value is reached or the last column is read. The last load also normalises
//  every row. A steady-state item runs the power iterations, then emits one entry per state.
//  After reset the table valid bits read as uniform rows.
//  Results wait in an output register; no item is taken until it is free.
module markov_chain_sampler (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mcs_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mcs_pkg::out_item_t m_data
);
    localparam int N  = mcs_pkg::STATE_COUNT;
    localparam int IW = mcs_pkg::IDX_W;
    localparam int AW = mcs_pkg::ADDR_W;
    localparam int PW = mcs_pkg::PROB_W;
    localparam int SW = mcs_pkg::SUM_W;
    localparam int FB = mcs_pkg::PROB_FRACTION_BITS;

    mcs_pkg::fsm_t state_reg, state_next;
    mcs_pkg::in_item_t item_reg, item_next;

    logic [mcs_pkg::DEPTH-1:0] vld_reg, vld_next;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [PW-1:0] wdata, rdata, rword;

    logic [IW-1:0] row_reg, row_next, col_reg, col_next;
    logic          rd_reg, rd_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [SW-1:0] cum_reg, cum_next;
    logic [mcs_pkg::CNT_W-1:0] it_reg, it_next;
    logic [PW-1:0] dist_reg [N];
    logic [PW-1:0] dnext_reg [N];
    logic [PW-1:0] dist_next [N];
    logic [PW-1:0] dnx_next [N];
    logic [PW-1:0] prod_reg, prod_next;
    logic          pv_reg, pv_next;
    logic [IW-1:0] pcol_reg, pcol_next;

    logic          ov_reg, ov_next;
    mcs_pkg::out_item_t od_reg, od_next;

    mcs_pkg::div_req_t dreq;
    logic          ddone;
    logic [mcs_pkg::QUO_W-1:0] dquo;
    logic [2*PW-1:0] mul;
    logic [SW:0]   acc;
    logic [PW:0]   sadd;
    logic [IW-1:0] cur;

    mcs_ram #(.WIDTH(PW), .DEPTH(mcs_pkg::DEPTH)) u_table (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    mcs_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .done(ddone), .quo(dquo));

    logic vld_rd_reg;
    always_ff @(posedge aclk) vld_rd_reg <= vld_reg[raddr];
    assign rword = vld_rd_reg ? rdata : mcs_pkg::UNIFORM_PROB;

    assign s_ready = (state_reg == mcs_pkg::ST_IDLE) && !ov_reg;
    assign m_valid = ov_reg;
    assign m_data  = od_reg;
    assign cur = (s_data.current_state > mcs_pkg::LAST_STATE) ? mcs_pkg::LAST_STATE
                                                             : s_data.current_state;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mcs_pkg::ST_IDLE:
                if (s_valid && s_ready) begin
                    if (s_data.kind == mcs_pkg::KIND_LOAD && s_data.load_end)
                        state_next = mcs_pkg::ST_NSUM;
                    else if (s_data.kind == mcs_pkg::KIND_SAMPLE)
                        state_next = mcs_pkg::ST_SAMP;
                    else if (s_data.kind == mcs_pkg::KIND_STEADY)
                        state_next = mcs_pkg::ST_PINIT;
                end
            mcs_pkg::ST_SAMP:
                if (rd_reg && (((SW+1)'(item_reg.random_value) <= acc) ||
                               col_reg == mcs_pkg::LAST_STATE))
                    state_next = mcs_pkg::ST_IDLE;
            mcs_pkg::ST_NSUM:
                if (rd_reg && col_reg == mcs_pkg::LAST_STATE) state_next = mcs_pkg::ST_NDIV;
            mcs_pkg::ST_NDIV:
                if (sum_reg == '0 || ddone) state_next = mcs_pkg::ST_NWR;
            mcs_pkg::ST_NWR:
                if (col_reg == mcs_pkg::LAST_STATE)
                    state_next = (row_reg == mcs_pkg::LAST_STATE) ? mcs_pkg::ST_IDLE
                                                                  : mcs_pkg::ST_NSUM;
                else state_next = mcs_pkg::ST_NDIV;
            mcs_pkg::ST_PINIT:
                state_next = (it_reg == '0) ? mcs_pkg::ST_EMIT : mcs_pkg::ST_PMUL;
            mcs_pkg::ST_PMUL:
                if (pv_reg && pcol_reg == mcs_pkg::LAST_STATE && row_reg == mcs_pkg::LAST_STATE
                    && !rd_reg)
                    state_next = mcs_pkg::ST_PCOPY;
            mcs_pkg::ST_PCOPY:
                state_next = (it_reg == 1) ? mcs_pkg::ST_EMIT : mcs_pkg::ST_PMUL;
            mcs_pkg::ST_EMIT:
                if (!ov_reg && row_reg == mcs_pkg::LAST_STATE) state_next = mcs_pkg::ST_IDLE;
            default: state_next = mcs_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        item_next = item_reg; vld_next = vld_reg;
        row_next = row_reg; col_next = col_reg; rd_next = 1'b0;
        sum_next = sum_reg; cum_next = cum_reg; it_next = it_reg;
        prod_next = prod_reg; pv_next = 1'b0; pcol_next = pcol_reg;
        ov_next = ov_reg; od_next = od_reg;
        dist_next = dist_reg; dnx_next = dnext_reg;
        we = 1'b0; waddr = {row_reg, col_reg}; wdata = '0;
        raddr = {row_reg, col_reg};
        dreq = '0;
        acc = {1'b0, cum_reg} + (SW+1)'(rword);
        mul = dist_reg[row_reg] * rword;
        sadd = {1'b0, dnext_reg[pcol_reg]} + {1'b0, prod_reg};
        if (ov_reg && m_ready) ov_next = 1'b0;
        case (state_reg)
            mcs_pkg::ST_IDLE:
                if (s_valid && s_ready) begin
                    item_next = s_data;
                    row_next = '0; col_next = '0; cum_next = '0; sum_next = sum_reg;
                    it_next = s_data.iteration_count;
                    if (s_data.kind == mcs_pkg::KIND_LOAD) begin
                        we = 1'b1;
                        waddr = {s_data.row_index, s_data.column_index};
                        wdata = PW'(s_data.weight_value);
                        vld_next[waddr] = 1'b1;
                        sum_next = '0;
                    end else if (s_data.kind == mcs_pkg::KIND_SAMPLE) begin
                        row_next = cur;
                        raddr = {cur, IW'(0)};
                        rd_next = 1'b1;
                    end
                end
            mcs_pkg::ST_SAMP: begin
                raddr = {row_reg, col_reg + 1'b1};
                if (rd_reg) begin
                    cum_next = acc[SW-1:0];
                    if (((SW+1)'(item_reg.random_value) <= acc) ||
                        col_reg == mcs_pkg::LAST_STATE) begin
                        ov_next = 1'b1;
                        od_next = '{result_kind: 1'b0, next_state: col_reg,
                                    entry_index: '0, probability: '0, last: 1'b1};
                    end else begin
                        col_next = col_reg + 1'b1;
                        rd_next = 1'b1;
                    end
                end
            end
            mcs_pkg::ST_NSUM: begin
                if (!rd_reg && col_reg == '0 && sum_reg == '0 && cum_reg == '0) begin
                    raddr = {row_reg, IW'(0)};
                    rd_next = 1'b1;
                    cum_next = SW'(1);
                end else if (rd_reg) begin
                    sum_next = sum_reg + SW'(rword);
                    if (col_reg == mcs_pkg::LAST_STATE) begin
                        col_next = '0; cum_next = '0;
                    end else begin
                        col_next = col_reg + 1'b1;
                        raddr = {row_reg, col_reg + 1'b1};
                        rd_next = 1'b1;
                    end
                end
            end
            mcs_pkg::ST_NDIV: begin
                raddr = {row_reg, col_reg};
                if (!rd_reg && !pv_reg && cum_reg == '0) begin
                    rd_next = 1'b1; cum_next = SW'(1);
                end else if (rd_reg) begin
                    dreq.start = (sum_reg != '0);
                    dreq.num = {rword, FB'(0)};
                    dreq.den = sum_reg;
                end
                if (ddone) prod_next = (dquo > mcs_pkg::QUO_W'(mcs_pkg::PROB_MAX))
                                       ? mcs_pkg::PROB_MAX : dquo[PW-1:0];
                pv_next = 1'b0;
            end
            mcs_pkg::ST_NWR: begin
                we = 1'b1;
                waddr = {row_reg, col_reg};
                wdata = (sum_reg == '0) ? mcs_pkg::UNIFORM_PROB : prod_reg;
                vld_next[waddr] = 1'b1;
                cum_next = '0;
                if (col_reg == mcs_pkg::LAST_STATE) begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                    sum_next = '0;
                end else col_next = col_reg + 1'b1;
            end
            mcs_pkg::ST_PINIT: begin
                for (int k = 0; k < N; k++) begin
                    dist_next[k] = mcs_pkg::UNIFORM_PROB;
                    dnx_next[k] = '0;
                end
                row_next = '0; col_next = '0;
                raddr = '0;
                rd_next = (it_reg != '0);
            end
            mcs_pkg::ST_PMUL: begin
                if (pv_reg)
                    dnx_next[pcol_reg] = sadd[PW] ? mcs_pkg::PROB_MAX : sadd[PW-1:0];
                if (rd_reg) begin
                    prod_next = mul[FB+PW-1:FB];
                    pv_next = 1'b1;
                    pcol_next = col_reg;
                    if (!(row_reg == mcs_pkg::LAST_STATE && col_reg == mcs_pkg::LAST_STATE)) begin
                        col_next = col_reg + 1'b1;
                        if (col_reg == mcs_pkg::LAST_STATE) row_next = row_reg + 1'b1;
                        raddr = (col_reg == mcs_pkg::LAST_STATE) ? {row_reg + 1'b1, IW'(0)}
                                                                : {row_reg, col_reg + 1'b1};
                        rd_next = 1'b1;
                    end
                end
            end
            mcs_pkg::ST_PCOPY: begin
                for (int k = 0; k < N; k++) begin
                    dist_next[k] = dnext_reg[k];
                    dnx_next[k] = '0;
                end
                it_next = it_reg - 1'b1;
                row_next = '0; col_next = '0;
                raddr = '0;
                rd_next = (it_reg != 1);
                if (it_reg == 1) row_next = '0;
            end
            mcs_pkg::ST_EMIT:
                if (!ov_reg) begin
                    ov_next = 1'b1;
                    od_next = '{result_kind: 1'b1, next_state: '0, entry_index: row_reg,
                                probability: dist_reg[row_reg],
                                last: row_reg == mcs_pkg::LAST_STATE};
                    row_next = row_reg + 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mcs_pkg::ST_IDLE;
            vld_reg <= '0;
            ov_reg <= 1'b0;
            rd_reg <= 1'b0;
            pv_reg <= 1'b0;
            sum_reg <= '0;
            cum_reg <= '0;
        end else begin
            state_reg <= state_next;
            vld_reg <= vld_next;
            ov_reg <= ov_next;
            rd_reg <= rd_next;
            pv_reg <= pv_next;
            sum_reg <= sum_next;
            cum_reg <= cum_next;
        end
        item_reg <= item_next;
        row_reg <= row_next; col_reg <= col_next;
        it_reg <= it_next; prod_reg <= prod_next; pcol_reg <= pcol_next;
        od_reg <= od_next;
        dist_reg <= dist_next; dnext_reg <= dnx_next;
    end
endmodule
